@@ rtl/b64d_pkg.sv @@
package b64d_pkg;

  localparam int SYM_W   = 8;
  localparam int LEN_W   = 14;
  localparam int MAX_RES = 4;
  localparam int QDEPTH  = 3 * MAX_RES;
  localparam int QCW     = $clog2(QDEPTH + 1);

  localparam logic [LEN_W-1:0] CAP_RESET = LEN_W'(8192);
  localparam logic [LEN_W-1:0] LEN_MAX   = {LEN_W{1'b1}};

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_SYMBOL = 2'd1,
    ST_BAD_LENGTH = 2'd2,
    ST_NO_SPACE   = 2'd3
  } status_t;

  typedef struct packed {
    logic             is_pad;
    logic             is_bad;
    logic [5:0]       val;
  } sextet_t;

  typedef struct packed {
    logic [7:0]       data_byte;
    logic             eom;
    status_t          status;
    logic [LEN_W-1:0] len;
  } res_t;

  typedef struct packed {
    logic [2:0]       cnt;
    res_t [3:0]       ent;
  } push_t;

  function automatic sextet_t sextet_of(input logic [SYM_W-1:0] ch);
    sextet_t s;
    logic [7:0] d;
    s = '0;
    d = 8'h00;
    if (ch >= 8'h41 && ch <= 8'h5A) begin
      d = ch - 8'h41;
    end else if (ch >= 8'h61 && ch <= 8'h7A) begin
      d = ch - 8'h61 + 8'd26;
    end else if (ch >= 8'h30 && ch <= 8'h39) begin
      d = ch - 8'h30 + 8'd52;
    end else if (ch == 8'h2B) begin
      d = 8'd62;
    end else if (ch == 8'h2F) begin
      d = 8'd63;
    end else if (ch == 8'h3D) begin
      s.is_pad = 1'b1;
    end else begin
      s.is_bad = 1'b1;
    end
    s.val = d[5:0];
    return s;
  endfunction

endpackage

@@ rtl/b64d_resq.sv @@
module b64d_resq (
  input  logic          clk,
  input  logic          rst_n,
  input  b64d_pkg::push_t push,
  output logic          room,
  output logic          out_valid,
  input  logic          out_ready,
  output b64d_pkg::res_t  out_res
);
  import b64d_pkg::*;

  res_t           q_r   [QDEPTH];
  res_t           q_nxt [QDEPTH];
  logic [QCW-1:0] cnt_r;
  logic [QCW-1:0] cnt_nxt;
  logic [QCW-1:0] base;
  logic [QCW-1:0] off;
  logic           pop;

  assign out_valid = (cnt_r != '0);
  assign out_res   = q_r[0];
  // worst case: one word in the input register and one arriving
  assign room      = (cnt_r <= QCW'(QDEPTH - 2 * MAX_RES));

  always_comb begin
    pop  = out_valid && out_ready;
    base = cnt_r - QCW'(pop);
    off  = '0;
    for (int i = 0; i < QDEPTH; i++) begin
      q_nxt[i] = q_r[i];
      if (QCW'(i) < base) begin
        if (pop) begin
          q_nxt[i] = q_r[(i + 1) % QDEPTH];
        end
      end else begin
        off = QCW'(i) - base;
        if (off < QCW'(push.cnt)) begin
          q_nxt[i] = push.ent[off[1:0]];
        end
      end
    end
    cnt_nxt = base + QCW'(push.cnt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QDEPTH; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCW'(QDEPTH))
    else $error("result queue count out of range");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (({1'b0, base} + (QCW + 1)'(push.cnt)) <= (QCW + 1)'(QDEPTH)))
    else $error("result queue overrun");

  a_pop_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && cnt_r > QCW'(1)) |=> (q_r[0] == $past(q_r[1])))
    else $error("result queue did not advance");

endmodule

@@ rtl/b64d_core.sv @@
module b64d_core #(
  parameter int MAX_OUTPUT = 8192
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        room,
  input  logic [b64d_pkg::SYM_W-1:0]  in_symbol,
  input  logic                        in_last_symbol,
  input  logic                        cfg_we,
  input  logic [b64d_pkg::LEN_W-1:0]  cfg_wdata,
  output b64d_pkg::push_t             push
);
  import b64d_pkg::*;

  localparam logic [LEN_W-1:0] MAX_LIM =
    (MAX_OUTPUT > int'(LEN_MAX)) ? LEN_MAX : LEN_W'(MAX_OUTPUT);

  logic [SYM_W-1:0] sym_r;
  logic             last_r;
  logic             inv_r;
  logic [LEN_W-1:0] cap_r;
  logic [1:0]       pos_r, pos_nxt;
  logic [5:0]       h0_r, h0_nxt;
  logic [5:0]       h1_r, h1_nxt;
  logic [5:0]       h2_r, h2_nxt;
  logic             tip_r, tip_nxt;
  logic [LEN_W-1:0] emit_r, emit_nxt;
  status_t          err_r, err_nxt;
  logic             pads_r, pads_nxt;
  sextet_t          sx;
  logic [1:0]       dcnt;
  logic [1:0]       qcnt;
  logic [LEN_W-1:0] limit;
  logic [LEN_W:0]   sum;
  logic [1:0]       pos_inc;
  status_t          end_st;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_r <= 1'b0;
    end else begin
      inv_r <= in_valid && room;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && room) begin
      sym_r  <= in_symbol;
      last_r <= in_last_symbol;
    end
  end

  always_comb begin
    sx       = sextet_of(sym_r);
    limit    = (cap_r > MAX_LIM) ? MAX_LIM : cap_r;
    pos_nxt  = pos_r;
    h0_nxt   = h0_r;
    h1_nxt   = h1_r;
    h2_nxt   = h2_r;
    tip_nxt  = tip_r;
    emit_nxt = emit_r;
    err_nxt  = err_r;
    pads_nxt = pads_r;
    dcnt     = 2'd0;
    qcnt     = 2'd0;
    sum      = '0;
    pos_inc  = pos_r + 2'd1;
    end_st   = ST_OK;
    push     = '0;
    if (inv_r) begin
      if (err_r == ST_OK && !pads_r) begin
        unique case (pos_r)
          2'd0, 2'd1: begin
            if (sx.is_pad || sx.is_bad) begin
              err_nxt = ST_BAD_SYMBOL;
            end else if (pos_r[0]) begin
              h1_nxt = sx.val;
            end else begin
              h0_nxt = sx.val;
            end
          end
          2'd2: begin
            if (sx.is_bad) begin
              err_nxt = ST_BAD_SYMBOL;
            end else if (sx.is_pad) begin
              tip_nxt = 1'b1;
            end else begin
              h2_nxt  = sx.val;
              tip_nxt = 1'b0;
            end
          end
          default: begin
            if (sx.is_bad) begin
              err_nxt = ST_BAD_SYMBOL;
            end else if (tip_r) begin
              if (sx.is_pad) qcnt = 2'd1;
              else err_nxt = ST_BAD_SYMBOL;
            end else if (sx.is_pad) begin
              qcnt = 2'd2;
            end else begin
              qcnt = 2'd3;
            end
            if (qcnt != 2'd0) begin
              sum = {1'b0, emit_r} + (LEN_W + 1)'(qcnt);
              if (sum > {1'b0, limit}) begin
                err_nxt = ST_NO_SPACE;
              end else begin
                dcnt = qcnt;
                push.ent[0].data_byte = {h0_r, h1_r[5:4]};
                push.ent[1].data_byte = {h1_r[3:0], h2_r[5:2]};
                push.ent[2].data_byte = {h2_r[1:0], sx.val};
                emit_nxt = sum[LEN_W-1:0];
                if (qcnt != 2'd3) pads_nxt = 1'b1;
              end
            end
            tip_nxt = 1'b0;
          end
        endcase
      end
      pos_nxt = pos_inc;
      // unused data slots are cleared to zero here; the queue also ignores them by count
      for (int i = 0; i < 3; i++) begin
        if (2'(i) >= dcnt) push.ent[i].data_byte = 8'h00;
      end
      push.cnt = {1'b0, dcnt};
      if (last_r) begin
        end_st = (pos_inc != 2'd0) ? ST_BAD_LENGTH : err_nxt;
        push.ent[dcnt].data_byte = 8'h00;
        push.ent[dcnt].eom       = 1'b1;
        push.ent[dcnt].status    = end_st;
        push.ent[dcnt].len       = emit_nxt;
        push.cnt = {1'b0, dcnt} + 3'd1;
        pos_nxt  = 2'd0;
        tip_nxt  = 1'b0;
        emit_nxt = '0;
        err_nxt  = ST_OK;
        pads_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r  <= CAP_RESET;
      pos_r  <= 2'd0;
      tip_r  <= 1'b0;
      emit_r <= '0;
      err_r  <= ST_OK;
      pads_r <= 1'b0;
    end else begin
      if (cfg_we) cap_r <= cfg_wdata;
      pos_r  <= pos_nxt;
      tip_r  <= tip_nxt;
      emit_r <= emit_nxt;
      err_r  <= err_nxt;
      pads_r <= pads_nxt;
    end
  end

  always_ff @(posedge clk) begin
    h0_r <= h0_nxt;
    h1_r <= h1_nxt;
    h2_r <= h2_nxt;
  end

  a_pad_err_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(pads_r && err_r != ST_OK))
    else $error("padding and error both set");

  a_no_push_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !inv_r |-> (push.cnt == 3'd0))
    else $error("result pushed without a word");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (inv_r && last_r) |=> (pos_r == 2'd0 && emit_r == '0 && err_r == ST_OK))
    else $error("message state not cleared after last word");

endmodule

@@ rtl/base64_stream_decoder.sv @@
// Channel   Ports                                                  Width
// in        in_valid, in_ready, in_symbol, in_last_symbol          8 + 1
// out       out_valid, out_ready, out_data_byte, out_end_of_message,
//           out_status, out_decoded_length                         8 + 1 + 2 + 14
// cfg       cfg_we, cfg_wdata (output capacity)                    14
//
// One word accepted per cycle while in_ready; it passes the input register and queue.
// A word yields 0 to 4 results, drained one per cycle while out_ready is high.
// in_ready drops while the 12-entry result queue holds more than 4 results.
// rst_n is synchronous; capacity resets to 8192, message state to empty.
module base64_stream_decoder #(
  parameter int MAX_OUTPUT = 8192
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [b64d_pkg::SYM_W-1:0]  in_symbol,
  input  logic                        in_last_symbol,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [7:0]                  out_data_byte,
  output logic                        out_end_of_message,
  output logic [1:0]                  out_status,
  output logic [b64d_pkg::LEN_W-1:0]  out_decoded_length,
  input  logic                        cfg_we,
  input  logic [b64d_pkg::LEN_W-1:0]  cfg_wdata
);
  import b64d_pkg::*;

  push_t push;
  res_t  head;
  logic  room;

  assign in_ready = room;

  b64d_core #(
    .MAX_OUTPUT(MAX_OUTPUT)
  ) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .room          (room),
    .in_symbol     (in_symbol),
    .in_last_symbol(in_last_symbol),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .push          (push)
  );

  b64d_resq u_resq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .room     (room),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_res  (head)
  );

  assign out_data_byte      = head.data_byte;
  assign out_end_of_message = head.eom;
  assign out_status         = head.status;
  assign out_decoded_length = head.len;

endmodule

@@ tb/b64d_checker.sv @@
`timescale 1ns / 100ps
module b64d_checker #(
  parameter int MAX_OUTPUT = 8192
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic [b64d_pkg::SYM_W-1:0] in_symbol,
  input  logic                       in_last_symbol,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic [7:0]                 out_data_byte,
  input  logic                       out_end_of_message,
  input  logic [1:0]                 out_status,
  input  logic [b64d_pkg::LEN_W-1:0] out_decoded_length,
  input  logic                       cfg_we,
  input  logic [b64d_pkg::LEN_W-1:0] cfg_wdata,
  output int                         fail_count,
  output int                         pending,
  output int                         results_seen
);
  import b64d_pkg::*;

  localparam int PAD_CODE = 64;
  localparam int BAD_CODE = 65;

  logic [LEN_W-1:0] capacity;
  logic [1:0]       quad_pos;
  logic [5:0]       held [3];
  logic             third_pad;
  logic             pad_seen;
  logic [LEN_W-1:0] emitted;
  status_t          err;
  res_t             due_results [$];

  initial begin
    fail_count   = 0;
    pending      = 0;
    results_seen = 0;
  end

  function automatic int char_code(input logic [7:0] ch);
    if (ch >= "A" && ch <= "Z") return int'(ch - "A");
    if (ch >= "a" && ch <= "z") return int'(ch - "a") + 26;
    if (ch >= "0" && ch <= "9") return int'(ch - "0") + 52;
    if (ch == "+") return 62;
    if (ch == "/") return 63;
    if (ch == "=") return PAD_CODE;
    return BAD_CODE;
  endfunction

  function automatic void queue_result(input logic [7:0] d, input logic eom,
                                       input status_t st, input logic [LEN_W-1:0] len);
    res_t r;
    r.data_byte = d;
    r.eom       = eom;
    r.status    = st;
    r.len       = len;
    due_results.push_back(r);
  endfunction

  task automatic decode_symbol(input logic [7:0] ch, input logic lst);
    int          code;
    int          count;
    int          limit;
    logic [23:0] bits;
    code  = char_code(ch);
    count = 0;
    if (err == ST_OK && !pad_seen) begin
      if (quad_pos < 2) begin
        if (code >= PAD_CODE) err = ST_BAD_SYMBOL;
        else held[quad_pos] = code[5:0];
      end else if (quad_pos == 2) begin
        if (code == BAD_CODE) begin
          err = ST_BAD_SYMBOL;
        end else if (code == PAD_CODE) begin
          third_pad = 1'b1;
        end else begin
          held[2]   = code[5:0];
          third_pad = 1'b0;
        end
      end else begin
        if (code == BAD_CODE) begin
          err = ST_BAD_SYMBOL;
        end else if (third_pad) begin
          if (code == PAD_CODE) count = 1;
          else err = ST_BAD_SYMBOL;
        end else if (code == PAD_CODE) begin
          count = 2;
        end else begin
          count = 3;
        end
        if (count != 0) begin
          limit = (capacity > MAX_OUTPUT) ? MAX_OUTPUT : int'(capacity);
          if (int'(emitted) + count > limit) begin
            err = ST_NO_SPACE;
          end else begin
            bits = {held[0], held[1], 12'd0};
            if (count >= 2) bits[11:6] = held[2];
            if (count == 3) bits[5:0] = code[5:0];
            queue_result(bits[23:16], 1'b0, ST_OK, '0);
            if (count >= 2) queue_result(bits[15:8], 1'b0, ST_OK, '0);
            if (count == 3) queue_result(bits[7:0], 1'b0, ST_OK, '0);
            emitted = emitted + LEN_W'(count);
            if (count < 3) pad_seen = 1'b1;
          end
        end
        third_pad = 1'b0;
      end
    end
    quad_pos = quad_pos + 2'd1;
    if (lst) begin
      queue_result(8'h00, 1'b1, (quad_pos != 0) ? ST_BAD_LENGTH : err, emitted);
      quad_pos  = '0;
      third_pad = 1'b0;
      emitted   = '0;
      err       = ST_OK;
      pad_seen  = 1'b0;
    end
  endtask

  task automatic check_result();
    res_t want;
    results_seen++;
    if (due_results.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("%0t: unexpected result byte %02h eom %0b status %0d len %0d", $time,
                 out_data_byte, out_end_of_message, out_status, out_decoded_length);
    end else begin
      want = due_results.pop_front();
      if (out_data_byte !== want.data_byte || out_end_of_message !== want.eom ||
          out_status !== want.status || out_decoded_length !== want.len) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("%0t: expected byte %02h eom %0b status %0d len %0d",
                   $time, want.data_byte, want.eom, want.status, want.len);
          $display("%0t:      got byte %02h eom %0b status %0d len %0d",
                   $time, out_data_byte, out_end_of_message, out_status,
                   out_decoded_length);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      capacity  = CAP_RESET;
      quad_pos  = '0;
      held[0]   = '0;
      held[1]   = '0;
      held[2]   = '0;
      third_pad = 1'b0;
      pad_seen  = 1'b0;
      emitted   = '0;
      err       = ST_OK;
      due_results.delete();
    end else begin
      if (cfg_we) capacity = cfg_wdata;
      if (in_valid && in_ready) decode_symbol(in_symbol, in_last_symbol);
      if (out_valid && out_ready) check_result();
    end
    pending = due_results.size();
  end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
module tb;
  import b64d_pkg::*;

  localparam int MAX_OUT     = 8192;
  localparam int LIMIT       = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int DIRECTED    = 27;
  localparam int PHASE_WORDS = 56;

  logic             clk            = 1'b0;
  logic             rst_n          = 1'b0;
  logic             in_valid       = 1'b0;
  logic             in_ready;
  logic [SYM_W-1:0] in_symbol      = '0;
  logic             in_last_symbol = 1'b0;
  logic             out_valid;
  logic             out_ready      = 1'b0;
  logic [7:0]       out_data_byte;
  logic             out_end_of_message;
  logic [1:0]       out_status;
  logic [LEN_W-1:0] out_decoded_length;
  logic             cfg_we         = 1'b0;
  logic [LEN_W-1:0] cfg_wdata      = '0;

  int fail_count;
  int pending;
  int results_seen;

  int         cycles      = 0;
  int         words_sent  = 0;
  int         msgs_sent   = 0;
  int         caps_written = 0;
  int         burst_left  = 0;
  bit         hold_req    = 1'b0;
  logic [7:0] msg [$];

  always #10 clk = ~clk;

  base64_stream_decoder #(.MAX_OUTPUT(MAX_OUT)) u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_symbol          (in_symbol),
    .in_last_symbol     (in_last_symbol),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_data_byte      (out_data_byte),
    .out_end_of_message (out_end_of_message),
    .out_status         (out_status),
    .out_decoded_length (out_decoded_length),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata)
  );

  b64d_checker #(.MAX_OUTPUT(MAX_OUT)) u_chk (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_symbol          (in_symbol),
    .in_last_symbol     (in_last_symbol),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_data_byte      (out_data_byte),
    .out_end_of_message (out_end_of_message),
    .out_status         (out_status),
    .out_decoded_length (out_decoded_length),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .fail_count         (fail_count),
    .pending            (pending),
    .results_seen       (results_seen)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic logic [7:0] b64_char(input int i);
    if (i < 26) return 8'("A" + i);
    if (i < 52) return 8'("a" + i - 26);
    if (i < 62) return 8'("0" + i - 52);
    if (i == 62) return "+";
    return "/";
  endfunction

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) msg.push_back(s[i]);
  endfunction

  task automatic send_word(input logic [7:0] sym, input logic lst);
    if (burst_left == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 40);
    end
    in_valid       = 1'b1;
    in_symbol      = sym;
    in_last_symbol = lst;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    burst_left--;
    words_sent++;
  endtask

  task automatic send_msg();
    for (int i = 0; i < msg.size(); i++) send_word(msg[i], i == msg.size() - 1);
    msg.delete();
    msgs_sent++;
  endtask

  task automatic set_capacity(input logic [LEN_W-1:0] v);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
    caps_written++;
  endtask

  // mostly well-formed quads with random content; some broken or noise
  task automatic build_random_msg();
    int kind;
    int quads;
    int pad;
    int pos;
    kind = $urandom_range(0, 9);
    if (kind == 9) begin
      repeat ($urandom_range(1, 9)) msg.push_back(8'($urandom_range(0, 255)));
    end else begin
      quads = $urandom_range(1, 4);
      pad   = $urandom_range(0, 2);
      repeat (quads * 4) msg.push_back(b64_char($urandom_range(0, 63)));
      if (pad >= 1) msg[msg.size() - 1] = "=";
      if (pad == 2) msg[msg.size() - 2] = "=";
      if (pad != 0 && $urandom_range(0, 3) == 0)
        repeat (4) msg.push_back($urandom_range(0, 2) == 0 ? 8'("=") :
                                 b64_char($urandom_range(0, 63)));
      pos = $urandom_range(0, msg.size() - 1);
      case (kind)
        6: msg[pos] = 8'($urandom_range(0, 255));
        7: msg[pos] = "=";
        8: begin
          if ($urandom_range(0, 1) == 1)
            repeat ($urandom_range(1, 3)) msg.push_back(b64_char($urandom_range(0, 63)));
          else
            repeat ($urandom_range(1, 3)) void'(msg.pop_back());
        end
        default: ;
      endcase
    end
  endtask

  initial begin
    int       mode;
    int       mode_left;
    bit [7:0] pat;
    mode      = 0;
    mode_left = 0;
    pat       = 8'b1011_0110;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 80);
        end
        mode_left--;
        case (mode)
          0: out_ready = 1'b1;
          1: out_ready = ($urandom_range(0, 3) != 0);
          2: begin
            out_ready = pat[0];
            pat       = {pat[0], pat[7:1]};
          end
          default: out_ready = ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  initial begin
    logic [LEN_W-1:0] cap;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    add_text("AZaz09+/");
    send_msg();
    add_text("QQ==Az=+");
    send_msg();
    msg.push_back("=");
    msg.push_back(8'hFF);
    add_text("AA");
    send_msg();
    add_text("AB=C");
    send_msg();
    add_text("ABC");
    send_msg();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: cap = '1;
        1: cap = '0;
        2: cap = CAP_RESET;
        3: cap = LEN_W'($urandom_range(1, 12));
        4: cap = LEN_W'($urandom_range(4, 40));
        5: cap = LEN_W'($urandom_range(1, 12));
        6: cap = LEN_W'(MAX_OUT);
        default: cap = LEN_W'($urandom_range(0, MAX_OUT));
      endcase
      set_capacity(cap);
      if (p == 2) hold_req = 1'b1;
      while (words_sent < DIRECTED + (p + 1) * PHASE_WORDS) begin
        build_random_msg();
        send_msg();
      end
    end

    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (12) @(negedge clk);
    $display("covered %0d words in %0d messages, %0d results checked, %0d capacity writes",
             words_sent, msgs_sent, results_seen, caps_written);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/b64d_pkg.sv
rtl/b64d_resq.sv
rtl/b64d_core.sv
rtl/base64_stream_decoder.sv
tb/b64d_checker.sv
tb/tb.sv
